// ----- sv/sjis_pkg.sv -----
// ----------------------------------------------------------------------------
// sjis_pkg
// Shared types and constants of the Shift-JIS to UTF-8 stream converter.
// ----------------------------------------------------------------------------
package sjis_pkg;

	localparam int TABLE_DEPTH = 8192;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W       = 14;
	localparam int ENTRY_IDX_W = 13;
	localparam int CODE_W      = 16;

	localparam logic [CODE_W-1:0] MISS_CODE = 16'h0020;
	localparam logic [7:0]        ASCII_END = 8'h80;
	localparam logic [7:0]        KANA_LO   = 8'hA1;
	localparam logic [7:0]        KANA_HI   = 8'hDF;

	localparam logic [CODE_W-1:0] ONE_BYTE_MAX = 16'h007F;
	localparam logic [CODE_W-1:0] TWO_BYTE_MAX = 16'h07FF;
	localparam logic [7:0]        LEAD2_MARK   = 8'hC0;
	localparam logic [7:0]        LEAD3_MARK   = 8'hE0;
	localparam logic [7:0]        CONT_MARK    = 8'h80;

	typedef struct packed {
		logic [CODE_W-1:0] key;
		logic [CODE_W-1:0] value;
	} sjis_entry_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] unicode;
	} sjis_uni_t;

endpackage

// ----- sv/sjis_map_ram.sv -----
// ----------------------------------------------------------------------------
// sjis_map_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sjis_map_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/sjis_search.sv -----
// ----------------------------------------------------------------------------
// sjis_search
// Item intake, table load, lead byte pairing and binary search of the table.
// ----------------------------------------------------------------------------
module sjis_search (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [7:0]                            byte_in,
	input  logic                                  final_byte,
	input  logic [sjis_pkg::ENTRY_IDX_W-1:0]      entry_index,
	input  logic [sjis_pkg::CODE_W-1:0]           entry_sjis,
	input  logic [sjis_pkg::CODE_W-1:0]           entry_unicode,
	input  logic [sjis_pkg::BOUND_W-1:0]          limit,
	output logic                                  ram_we,
	output logic [sjis_pkg::IDX_W-1:0]            ram_waddr,
	output sjis_pkg::sjis_entry_t                 ram_wdata,
	output logic                                  ram_re,
	output logic [sjis_pkg::IDX_W-1:0]            ram_raddr,
	input  sjis_pkg::sjis_entry_t                 ram_rdata,
	output sjis_pkg::sjis_uni_t                   uni,
	input  logic                                  uni_ready
);
	import sjis_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_CMP  = 4'b0100,
		S_SEND = 4'b1000
	} sjis_state_t;

	sjis_state_t          state_q;
	logic [BOUND_W-1:0]   lo_q;
	logic [BOUND_W-1:0]   hi_q;
	logic [BOUND_W-1:0]   mid_q;
	logic [BOUND_W-1:0]   mid;
	logic [CODE_W-1:0]    code_q;
	logic [CODE_W-1:0]    value_q;
	logic [7:0]           held_q;
	logic                 pending_q;
	logic                 accept;
	logic                 single;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign single   = (byte_in < ASCII_END) || (byte_in >= KANA_LO && byte_in <= KANA_HI);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);

	assign ram_we          = accept && !mode && (32'(entry_index) < TABLE_DEPTH);
	assign ram_waddr       = IDX_W'(entry_index);
	assign ram_wdata.key   = entry_sjis;
	assign ram_wdata.value = entry_unicode;
	assign ram_re          = (state_q == S_READ) && (lo_q < hi_q);
	assign ram_raddr       = mid[IDX_W-1:0];

	assign uni.valid   = (state_q == S_SEND);
	assign uni.unicode = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			held_q    <= '0;
			pending_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && mode) begin
						if (pending_q) begin
							pending_q <= 1'b0;
							held_q    <= '0;
							state_q   <= S_READ;
						end else if (single) begin
							state_q <= S_READ;
						end else if (!final_byte) begin
							held_q    <= byte_in;
							pending_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_SEND;
					end
				end
				S_CMP: begin
					if (ram_rdata.key == code_q) begin
						state_q <= S_SEND;
					end else begin
						state_q <= S_READ;
					end
				end
				S_SEND: begin
					if (uni_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				lo_q <= '0;
				hi_q <= limit;
				if (pending_q) begin
					code_q <= {held_q, byte_in};
				end else begin
					code_q <= CODE_W'(byte_in);
				end
			end
			S_READ: begin
				mid_q <= mid;
				if (!(lo_q < hi_q)) begin
					value_q <= MISS_CODE;
				end
			end
			S_CMP: begin
				if (ram_rdata.key == code_q) begin
					value_q <= ram_rdata.value;
				end else if (ram_rdata.key < code_q) begin
					lo_q <= mid_q + BOUND_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/sjis_utf8_emit.sv -----
// ----------------------------------------------------------------------------
// sjis_utf8_emit
// Splits one UTF-16 unit into one to three UTF-8 bytes behind an output
// register.
// ----------------------------------------------------------------------------
module sjis_utf8_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  sjis_pkg::sjis_uni_t uni,
	output logic                uni_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          utf8_byte,
	output logic                last_of_char
);
	import sjis_pkg::*;

	logic                busy_q;
	logic [CODE_W-1:0]   u_q;
	logic [1:0]          pos_q;
	logic                out_valid_q;
	logic [7:0]          byte_q;
	logic                last_q;
	logic [1:0]          len;
	logic [7:0]          cur_byte;
	logic                cur_last;
	logic                advance;

	always_comb begin
		if (u_q <= ONE_BYTE_MAX) begin
			len = 2'd1;
		end else if (u_q <= TWO_BYTE_MAX) begin
			len = 2'd2;
		end else begin
			len = 2'd3;
		end
	end

	always_comb begin
		cur_byte = {1'b0, u_q[6:0]};
		case (len)
			2'd2: begin
				if (pos_q == 2'd0) begin
					cur_byte = LEAD2_MARK | {3'b000, u_q[10:6]};
				end else begin
					cur_byte = CONT_MARK | {2'b00, u_q[5:0]};
				end
			end
			2'd3: begin
				if (pos_q == 2'd0) begin
					cur_byte = LEAD3_MARK | {4'b0000, u_q[15:12]};
				end else if (pos_q == 2'd1) begin
					cur_byte = CONT_MARK | {2'b00, u_q[11:6]};
				end else begin
					cur_byte = CONT_MARK | {2'b00, u_q[5:0]};
				end
			end
			default: begin
				cur_byte = {1'b0, u_q[6:0]};
			end
		endcase
	end

	assign cur_last     = (pos_q == len - 2'd1);
	assign advance      = busy_q && (!out_valid_q || !out_stall);
	assign uni_ready    = !busy_q;
	assign out_valid    = out_valid_q;
	assign utf8_byte    = byte_q;
	assign last_of_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (cur_last) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (uni.valid && !busy_q) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uni.valid && !busy_q) begin
			u_q <= uni.unicode;
		end
		if (advance) begin
			byte_q <= cur_byte;
			last_q <= cur_last;
		end
	end

endmodule

// ----- sv/sjis_to_utf8_stream_converter_unit.sv -----
// ----------------------------------------------------------------------------
// sjis_to_utf8_stream_converter_unit
// Shift-JIS to UTF-8 stream converter, table driven.
// ----------------------------------------------------------------------------
// Items with mode 0 load one table entry and leave the input unstalled. Items
// with mode 1 bring one text byte; every character is looked up by binary
// search over the first table_count entries of a one-port-read table RAM,
// each probe passing S_READ (address) and S_CMP (compare of the registered
// read data), at most 14 probes for a full table of 8192 entries; the
// result then waits until the encoder has finished the previous character.
// A lead byte alone is held and leaves the input unstalled. The one to
// three UTF-8 bytes leave through an output register at one byte a cycle
// while out_stall is low, and the next item is already being searched.
// The table has no reset; load every entry that table_count covers, sorted
// by key, before converting.
// ----------------------------------------------------------------------------
module sjis_to_utf8_stream_converter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sjis_pkg::CNT_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [7:0]                            byte_in,
	input  logic                                  final_byte,
	input  logic [sjis_pkg::ENTRY_IDX_W-1:0]      entry_index,
	input  logic [sjis_pkg::CODE_W-1:0]           entry_sjis,
	input  logic [sjis_pkg::CODE_W-1:0]           entry_unicode,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [7:0]                            utf8_byte,
	output logic                                  last_of_char
);
	import sjis_pkg::*;

	logic [CNT_W-1:0]    count_q;
	logic [BOUND_W-1:0]  limit;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	sjis_entry_t         ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	sjis_entry_t         ram_rdata;
	sjis_uni_t           uni;
	logic                uni_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (32'(count_q) > TABLE_DEPTH) begin
			limit = BOUND_W'(TABLE_DEPTH);
		end else begin
			limit = BOUND_W'(count_q);
		end
	end

	sjis_map_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH ($bits(sjis_entry_t)),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sjis_search u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.byte_in       (byte_in),
		.final_byte    (final_byte),
		.entry_index   (entry_index),
		.entry_sjis    (entry_sjis),
		.entry_unicode (entry_unicode),
		.limit         (limit),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.uni           (uni),
		.uni_ready     (uni_ready)
	);

	sjis_utf8_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.uni          (uni),
		.uni_ready    (uni_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.utf8_byte    (utf8_byte),
		.last_of_char (last_of_char)
	);

	a_uni_hold: assert property (@(posedge clk) disable iff (!arst_n)
		uni.valid && !uni_ready |=> uni.valid && $stable(uni.unicode))
		else $error("search result changed while waiting for the encoder");

	a_uni_done: assert property (@(posedge clk) disable iff (!arst_n)
		uni.valid && uni_ready |=> !uni.valid && !in_stall)
		else $error("search did not return to idle after handoff");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !mode |=> !in_stall)
		else $error("table load held the input side");

	a_char_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_char |=> out_valid)
		else $error("gap inside one UTF-8 character");

endmodule
